// File: src/bffa_pkg.sv
// shared types and constants of the bitmap first-fit allocator
// no dependencies; imported by the controller, the datapath and the top level
package bffa_pkg;

  // request kinds
  localparam logic [1:0] OP_QUERY   = 2'd0;
  localparam logic [1:0] OP_MARK    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_SEARCH  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  // field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 16;
  localparam int CFG_W   = 13;
  localparam int STAT_W  = 2;
  localparam int FOUND_W = 12;

  // map words of the memory, and width of limits that can reach 65536
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int LIM_W     = 17;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic rmw;
    logic scan;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic in_search;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

// File: src/bitmap_first_fit_allocator.sv
// top level of the bitmap first-fit allocator
// depends on bffa_pkg, bffa_ctrl and bffa_datapath
//
//  channel  | ports                                                          | direction
//  ---------+----------------------------------------------------------------+----------
//  request  | in_valid in_stall in_operation in_entry_index                  | in
//  result   | out_valid out_stall out_status out_entry_free out_found_index  | out
//  config   | cfg_we cfg_wdata (entries_in_use)                              | in
//
// query, mark, release: the map row is read as the request transfers, then checked and
// written back; search: map rows are read from row 0 on, up to ceil(min(entries_in_use,
// MAP_BITS)/32) rows (32 entries per row), until one holds a free entry below the limit
// reset: a clearing pass zeroes the ceil(MAP_BITS/32) map rows one per cycle (128 at
// 4096 entries) with in_stall high; one item is in work at a time
// a held result does not block the next request, whose result waits for out_stall low
module bitmap_first_fit_allocator
  import bffa_pkg::*;
#(
  parameter int MAP_BITS = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  // config register write
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [IDX_W-1:0]    in_entry_index,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STAT_W-1:0]   out_status,
  output logic                out_entry_free,
  output logic [FOUND_W-1:0]  out_found_index
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: clear pass, request accept, row read, scan, result hand-off
  bffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: map memory, search mask and priority pick, result register
  bffa_datapath #(
    .MAP_BITS (MAP_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_operation    (in_operation),
    .in_entry_index  (in_entry_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_free  (out_entry_free),
    .out_found_index (out_found_index),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// File: src/bffa_ctrl.sv
// sequencer of the bitmap first-fit allocator: clear pass, request, scan, result
// depends on bffa_pkg (cmd_t, sts_t)
module bffa_ctrl
  import bffa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.in_search ? S_SCAN : S_READ;
        end
      end
      S_READ: begin
        cmd.rmw   = 1'b1;
        state_nxt = S_FIN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit || sts.scan_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/bffa_datapath.sv
// map memory, scan logic, config register and result register of the allocator
// depends on bffa_pkg (codes, widths, cmd_t, sts_t)
module bffa_datapath
  import bffa_pkg::*;
#(
  parameter int MAP_BITS = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [IDX_W-1:0]    in_entry_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STAT_W-1:0]   out_status,
  output logic                out_entry_free,
  output logic [FOUND_W-1:0]  out_found_index,
  input  cmd_t                cmd,
  output sts_t                sts
);

  localparam int ROWS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RW   = $clog2(ROWS + 1);
  localparam logic [LIM_W-1:0] MAP_LIM = LIM_W'(MAP_BITS);

  // map memory, one word of entries per row, entry n at bit n%32 of row n/32
  logic [WORD_BITS-1:0] mem [ROWS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [CFG_W-1:0]   entries_r;
  logic [LIM_W-1:0]   limit;
  logic [RW-1:0]      nrows;

  logic [AW-1:0]      clr_r;
  logic [OP_W-1:0]    op_r;
  logic [BIT_W-1:0]   bit_r;
  logic [AW-1:0]      row_r;
  logic               range_r;

  logic [RW-1:0]      iss_r;
  logic [RW-1:0]      chk_r;
  logic               chk_vld_r;
  logic               iss_more;

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W-1:0]     first_j;
  logic [LIM_W-1:0]     found_full;
  logic                 cur_bit;
  logic [WORD_BITS-1:0] new_word;

  logic [STAT_W-1:0]  res_status_r;
  logic               res_free_r;
  logic [FOUND_W-1:0] res_found_r;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic               out_free_r;
  logic [FOUND_W-1:0] out_found_r;

  // search limit clipped to the map size, and rows that it touches
  assign limit = (LIM_W'(entries_r) > MAP_LIM) ? MAP_LIM : LIM_W'(entries_r);
  assign nrows = RW'((limit + LIM_W'(WORD_BITS - 1)) >> BIT_W);
  assign iss_more = (iss_r < nrows);

  // read port
  assign mem_re    = (cmd.accept && !sts.in_search) || (cmd.scan && iss_more);
  assign mem_raddr = cmd.scan ? iss_r[AW-1:0] : in_entry_index[AW+BIT_W-1:BIT_W];

  // bits of the checked row that lie below the limit
  always_comb begin
    mask = '1;
    if ((chk_r == (nrows - RW'(1))) && (limit[BIT_W-1:0] != '0)) begin
      mask = (WORD_BITS'(1) << limit[BIT_W-1:0]) - WORD_BITS'(1);
    end
  end

  assign free_bits = ~rd_data_r & mask;

  always_comb begin
    first_j = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        first_j = BIT_W'(j);
      end
    end
  end

  assign found_full = LIM_W'({chk_r[AW-1:0], first_j});

  // read-modify-write of one entry
  assign cur_bit = rd_data_r[bit_r];
  always_comb begin
    if (op_r == OP_MARK) begin
      new_word = rd_data_r | (WORD_BITS'(1) << bit_r);
    end else begin
      new_word = rd_data_r & ~(WORD_BITS'(1) << bit_r);
    end
  end

  // write port: clear pass or mark / release
  assign mem_we    = cmd.clear ||
                     (cmd.rmw && !range_r && ((op_r == OP_MARK) || (op_r == OP_RELEASE)));
  assign mem_waddr = cmd.clear ? clr_r : row_r;
  assign mem_wdata = cmd.clear ? '0 : new_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // status
  assign sts.clear_last = (clr_r == AW'(ROWS - 1));
  assign sts.in_search  = (in_operation == OP_SEARCH);
  assign sts.scan_hit   = chk_vld_r && (free_bits != '0);
  assign sts.scan_end   = !chk_vld_r && !iss_more;
  assign sts.out_free   = !out_valid_r || !out_stall;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r   <= '0;
      clr_r       <= '0;
      iss_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        entries_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.accept) begin
        iss_r     <= '0;
        chk_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        chk_vld_r <= iss_more;
        if (iss_more) begin
          iss_r <= iss_r + RW'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_operation;
      bit_r   <= in_entry_index[BIT_W-1:0];
      row_r   <= in_entry_index[AW+BIT_W-1:BIT_W];
      range_r <= ({1'b0, in_entry_index} >= MAP_LIM);
    end
    if (cmd.scan && iss_more) begin
      chk_r <= iss_r;
    end
    if (cmd.rmw) begin
      res_found_r <= '0;
      if (range_r) begin
        res_status_r <= ST_RANGE;
        res_free_r   <= 1'b0;
      end else begin
        res_status_r <= ST_OK;
        res_free_r   <= (op_r == OP_QUERY) && !cur_bit;
      end
    end else if (cmd.scan && sts.scan_hit) begin
      res_status_r <= ST_OK;
      res_free_r   <= 1'b0;
      res_found_r  <= found_full[FOUND_W-1:0];
    end else if (cmd.scan && sts.scan_end) begin
      res_status_r <= ST_NONE;
      res_free_r   <= 1'b0;
      res_found_r  <= '0;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_free_r   <= res_free_r;
      out_found_r  <= res_found_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_free  = out_free_r;
  assign out_found_index = out_found_r;

`ifndef SYNTH
  a_found_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && sts.scan_hit) |-> (found_full < limit))
    else $error("search hit at or above the limit");

  a_found_is_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && sts.scan_hit) |-> !rd_data_r[first_j])
    else $error("search hit on an allocated entry");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> !mem_we)
    else $error("map written during a search");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result register overwritten while held");
`endif

endmodule
